[design/assert_macros.svh]
// Assertion macros for the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When cond holds at a clock edge, expect must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
        else $error("assertion failed: cond implies expect_now");

// When cond holds at a clock edge, expect must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
        else $error("assertion failed: cond implies expect_next one cycle later");

`endif

[design/aac_pkg.sv]
// Package for the ADC average-and-calibrate block: widths, item types,
// register indexes and the pipeline control struct. No dependencies.
`default_nettype none

package aac_pkg;

    localparam int NUM_LANES         = 4;
    localparam int HIST_DEPTH        = 4;
    localparam int SLOT_W            = 2;
    localparam int SAMPLE_W          = 16;
    localparam int SUM_W             = 18;
    localparam int MEAN_W            = 12;
    localparam int SCALED_W          = 32;
    localparam int CAL_W             = 41;
    localparam int OFFSET_W          = 20;
    localparam int GAIN_W            = 16;
    localparam int SHIFT_W           = 5;
    localparam int GAIN_LSB          = 20;
    localparam int SHIFT_LSB         = 36;
    localparam int DIFF_W            = 21;
    localparam int PROD_W            = DIFF_W + GAIN_W;
    localparam int MEAN_AVG_SHIFT    = 6;
    localparam int MEAN_DIRECT_SHIFT = 4;
    localparam int CFG_IDX_W         = 3;

    localparam logic [CAL_W-1:0] CAL_RESET = CAL_W'(64'h10_0000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CHANNEL_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CHANNEL_1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CHANNEL_2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CHANNEL_3  = 3'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
    } t_in_item;

    typedef struct packed {
        logic [MEAN_W-1:0]          mean_0;
        logic [MEAN_W-1:0]          mean_1;
        logic [MEAN_W-1:0]          mean_2;
        logic [MEAN_W-1:0]          mean_3;
        logic signed [SCALED_W-1:0] scaled_0;
        logic signed [SCALED_W-1:0] scaled_1;
        logic signed [SCALED_W-1:0] scaled_2;
        logic signed [SCALED_W-1:0] scaled_3;
    } t_out_item;

    // Load enables for the three pipeline register ranks.
    typedef struct packed {
        logic ld_sum;
        logic ld_prod;
        logic ld_out;
    } t_pipe_ctl;

endpackage

`default_nettype wire

[design/aac_lane.sv]
// One channel lane: four-deep history, window sum, offset/gain multiply
// and arithmetic shift. Depends on aac_pkg.
`default_nettype none

module aac_lane
    import aac_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_pipe_ctl             i_ctl,
    input  wire logic                  i_avg_en,
    input  wire logic [SLOT_W-1:0]     i_slot,
    input  wire logic [CAL_W-1:0]      i_cal,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    output logic [MEAN_W-1:0]          o_mean,
    output logic signed [SCALED_W-1:0] o_scaled
);

    logic [SAMPLE_W-1:0] r_hist [HIST_DEPTH];
    logic [SUM_W-1:0]    n_value;
    logic [MEAN_W-1:0]   n_mean;
    logic [SUM_W-1:0]    r_value;
    logic [MEAN_W-1:0]   r_mean1;
    logic [SCALED_W-1:0] r_prod;
    logic [MEAN_W-1:0]   r_mean2;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [GAIN_W-1:0]   gain;
    logic signed [PROD_W-1:0]   prod;
    logic [SHIFT_W-1:0]         shamt;

    // The incoming sample replaces the row at the write slot, so the window
    // sum takes the new sample in that place and the stored rows elsewhere.
    always_comb begin
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < HIST_DEPTH; j++) begin
            if (i_slot == SLOT_W'(j)) begin
                acc = acc + SUM_W'(i_sample);
            end else begin
                acc = acc + SUM_W'(r_hist[j]);
            end
        end
        if (i_avg_en) begin
            n_value = acc;
            n_mean  = acc[MEAN_AVG_SHIFT +: MEAN_W];
        end else begin
            n_value = SUM_W'(i_sample);
            n_mean  = i_sample[MEAN_DIRECT_SHIFT +: MEAN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < HIST_DEPTH; j++) begin
                r_hist[j] <= '0;
            end
        end else if (i_ctl.ld_sum && i_avg_en) begin
            r_hist[i_slot] <= i_sample;
        end
    end

    assign diff  = $signed({{(DIFF_W-SUM_W){1'b0}}, r_value})
                 - $signed({i_cal[OFFSET_W-1], i_cal[OFFSET_W-1:0]});
    assign gain  = $signed(i_cal[GAIN_LSB +: GAIN_W]);
    assign prod  = PROD_W'(diff) * PROD_W'(gain);
    assign shamt = i_cal[SHIFT_LSB +: SHIFT_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_value <= n_value;
            r_mean1 <= n_mean;
        end
        if (i_ctl.ld_prod) begin
            r_prod  <= prod[SCALED_W-1:0];
            r_mean2 <= r_mean1;
        end
    end

    assign o_mean   = r_mean2;
    assign o_scaled = $signed(r_prod) >>> shamt;

endmodule

`default_nettype wire

[design/aac_pipe_ctrl.sv]
// Valid tracking and load enables for the three-rank pipeline with
// per-rank ready. Depends on aac_pkg.
`default_nettype none

module aac_pipe_ctrl
    import aac_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic r_v_sum;
    logic r_v_prod;
    logic r_v_out;
    logic rdy_out;
    logic rdy_prod;
    logic rdy_sum;

    // A rank can take new contents when it is empty or its contents move on.
    assign rdy_out  = !r_v_out || i_out_ready;
    assign rdy_prod = !r_v_prod || rdy_out;
    assign rdy_sum  = !r_v_sum || rdy_prod;

    assign o_ctl.ld_sum  = rdy_sum && i_in_valid;
    assign o_ctl.ld_prod = rdy_prod && r_v_sum;
    assign o_ctl.ld_out  = rdy_out && r_v_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sum  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (rdy_sum) begin
                r_v_sum <= i_in_valid;
            end
            if (rdy_prod) begin
                r_v_prod <= r_v_sum;
            end
            if (rdy_out) begin
                r_v_out <= r_v_prod;
            end
        end
    end

    assign o_in_ready  = rdy_sum;
    assign o_out_valid = r_v_out;

endmodule

`default_nettype wire

[design/adc_average_and_calibrate.sv]
// Top level of the ADC average-and-calibrate block: configuration registers,
// four channel lanes and the merging output register. Depends on aac_pkg,
// aac_lane and aac_pipe_ctrl.
`default_nettype none

// The block takes one item per clock cycle while o_in_ready is high and
// returns one result item for each, in the order the items were accepted.
// Each item carries four left-justified 12-bit conversion words, one per
// channel, and four identical lanes process them side by side. With averaging
// enabled, each lane writes its word into a four-deep history at the shared
// write slot and sums the window (rows never written count as zero); the mean
// is that sum shifted right by six. With averaging disabled the word itself
// stands in for the sum and the mean is the word shifted right by four. The
// corrected value is (sum - offset) * gain, kept to its low 32 bits, then
// shifted right arithmetically by the channel's shift. The pipeline is the
// sum rank, the multiply rank (one 21 by 16 bit multiplier per lane) and the
// output rank, where the shift is applied and the lane results are merged
// into one item. Each rank has its own ready, so a new item is taken while a
// finished result waits at the output as long as an earlier rank is free.
// Configuration writes are always accepted and take effect at once; they are
// to be made only while no item is in flight. Indexes beyond the last
// calibration register are ignored.
module adc_average_and_calibrate
    import aac_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CAL_W-1:0]     i_cfg_data
);

    logic                r_avg_en;
    logic [CAL_W-1:0]    r_cal [NUM_LANES];
    logic [SLOT_W-1:0]   r_slot;
    t_out_item           r_out;
    t_pipe_ctl           ctl;

    logic [SAMPLE_W-1:0]        samples [NUM_LANES];
    logic [MEAN_W-1:0]          means   [NUM_LANES];
    logic signed [SCALED_W-1:0] scaled  [NUM_LANES];

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unused data bits are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_en <= 1'b1;
            for (int c = 0; c < NUM_LANES; c++) begin
                r_cal[c] <= CAL_RESET;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AVERAGE_ENABLE: r_avg_en <= i_cfg_data[0];
                CFG_CAL_CHANNEL_0:  r_cal[0] <= i_cfg_data;
                CFG_CAL_CHANNEL_1:  r_cal[1] <= i_cfg_data;
                CFG_CAL_CHANNEL_2:  r_cal[2] <= i_cfg_data;
                CFG_CAL_CHANNEL_3:  r_cal[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The write slot advances only for items that enter the history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (ctl.ld_sum && r_avg_en) begin
            r_slot <= r_slot + SLOT_W'(1);
        end
    end

    aac_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    assign samples[0] = i_in_data.sample_0;
    assign samples[1] = i_in_data.sample_1;
    assign samples[2] = i_in_data.sample_2;
    assign samples[3] = i_in_data.sample_3;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        aac_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_avg_en (r_avg_en),
            .i_slot   (r_slot),
            .i_cal    (r_cal[g]),
            .i_sample (samples[g]),
            .o_mean   (means[g]),
            .o_scaled (scaled[g])
        );
    end

    // Merging stage: the lane results become one output item.
    always_ff @(posedge i_clk) begin
        if (ctl.ld_out) begin
            r_out.mean_0   <= means[0];
            r_out.mean_1   <= means[1];
            r_out.mean_2   <= means[2];
            r_out.mean_3   <= means[3];
            r_out.scaled_0 <= scaled[0];
            r_out.scaled_1 <= scaled[1];
            r_out.scaled_2 <= scaled[2];
            r_out.scaled_3 <= scaled[3];
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

[design/aac_checker.sv]
// Port-level checker for adc_average_and_calibrate and its bind statement.
// Depends on aac_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module aac_checker
    import aac_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire t_out_item            o_out_data,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready
);

    // A stalled result stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))

    // With nothing waiting at the output, every rank can move, so input is taken.
    `ASSERT_IMPLIES(a_empty_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // The block never blocks configuration writes.
    `ASSERT_IMPLIES(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind adc_average_and_calibrate aac_checker u_aac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire
